>>> rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared codes, widths and helpers for the pivot turn sequencer.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int PHASE_W = 3;
  localparam int FUNC_W  = 2;
  localparam int COUNT_W = 16;
  localparam int TRAVEL_W = 32;
  localparam int TARGET_W = 31;
  localparam int RUN_W   = 8;
  localparam int DUTY_W  = 7;
  localparam int DRIVE_W = 8;
  localparam int ADDR_W  = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_APPROACH = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEAVE    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_FIND     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_FAULT    = 3'd5;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ACK   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_APPROACH_TARGET = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CONFIRM_COUNT   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_LIMIT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_APPROACH_DUTY   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROTATE_DUTY     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LEFT_INVERT     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RIGHT_INVERT    = 3'd6;

  localparam logic [TARGET_W-1:0] RST_APPROACH_TARGET = 31'd1000;
  localparam logic [RUN_W-1:0]    RST_CONFIRM_COUNT   = 8'd3;
  localparam logic [COUNT_W-1:0]  RST_TIMEOUT_LIMIT   = 16'd800;
  localparam logic [DUTY_W-1:0]   RST_APPROACH_DUTY   = 7'd20;
  localparam logic [DUTY_W-1:0]   RST_ROTATE_DUTY     = 7'd30;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  typedef struct packed {
    logic [PHASE_W-1:0]        phase;
    logic                      start_accepted;
    logic                      drive_valid;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
  } result_t;

  function automatic logic [DUTY_W-1:0] duty_sat(input logic [DUTY_W-1:0] d);
    return (d > DUTY_MAX) ? DUTY_MAX : d;
  endfunction

endpackage

>>> rtl/core/pivot_turn_sequencer.sv
// ----------------------------------------------------------------------------
// pivot_turn_sequencer
// Junction turn sequencer: approach, leave line, find line, done or fault.
// ----------------------------------------------------------------------------
//  channel  | signals                               | transfer
//  ---------+---------------------------------------+------------------------------
//  input    | in_valid/in_ready + item fields       | in_valid & in_ready
//  result   | out_valid/out_ready + result fields   | out_valid & out_ready
//  config   | APB psel/penable/pwrite/paddr/pwdata  | psel & penable & pwrite
//
//  One item per cycle while in_ready is high; its result is registered in the
//  result register, or in the skid entry while the output stalls. All state is
//  updated at the input transfer edge by one combinational pass. A two-entry
//  output buffer (result register plus skid) keeps input open while one result
//  waits; in_ready drops only when both entries are full. rst is synchronous:
//  configuration returns to defaults, phase to idle.
module pivot_turn_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pts_pkg::FUNC_W-1:0]          func,
  input  logic                                direction,
  input  logic signed [pts_pkg::COUNT_W-1:0]  left_count,
  input  logic signed [pts_pkg::COUNT_W-1:0]  right_count,
  input  logic                                mid_left_black,
  input  logic                                mid_right_black,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pts_pkg::PHASE_W-1:0]         phase,
  output logic                                start_accepted,
  output logic                                drive_valid,
  output logic signed [pts_pkg::DRIVE_W-1:0]  left_drive,
  output logic signed [pts_pkg::DRIVE_W-1:0]  right_drive,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pts_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [pts_pkg::TARGET_W-1:0] approach_target;
  logic [pts_pkg::RUN_W-1:0]    confirm_count;
  logic [pts_pkg::COUNT_W-1:0]  timeout_limit;
  logic [pts_pkg::DUTY_W-1:0]   approach_duty;
  logic [pts_pkg::DUTY_W-1:0]   rotate_duty;
  logic                         left_sign_invert;
  logic                         right_sign_invert;

  logic [pts_pkg::PHASE_W-1:0]         phase_reg, phase_next;
  logic                                turn_dir, turn_dir_next;
  logic [pts_pkg::RUN_W-1:0]           confirm_run, confirm_run_next;
  logic [pts_pkg::COUNT_W-1:0]         tick_count, tick_count_next;
  logic [pts_pkg::COUNT_W-1:0]         last_left, last_left_next;
  logic [pts_pkg::COUNT_W-1:0]         last_right, last_right_next;
  logic signed [pts_pkg::TRAVEL_W-1:0] left_travel, left_travel_next;
  logic signed [pts_pkg::TRAVEL_W-1:0] right_travel, right_travel_next;

  logic                           in_xfer;
  logic                           cfg_write;
  logic [pts_pkg::REG_IDX_W-1:0]  reg_idx;

  logic [pts_pkg::COUNT_W-1:0]  tick_inc;
  logic                         timed_out;
  logic [pts_pkg::COUNT_W:0]    left_delta, right_delta;
  logic [pts_pkg::TRAVEL_W-1:0] left_sum, right_sum;
  logic                         travel_ok;
  logic                         confirm_cond;
  logic [pts_pkg::RUN_W-1:0]    run_inc;
  logic                         confirm_hit;
  logic [pts_pkg::RUN_W-1:0]    confirm_run_new;
  logic [pts_pkg::DUTY_W-1:0]   a_duty, r_duty;
  logic signed [pts_pkg::DRIVE_W-1:0] a_mag, r_mag;

  pts_pkg::result_t res;
  pts_pkg::result_t out_data, skid_data;
  logic             skid_valid;

  function automatic logic [pts_pkg::COUNT_W:0] unwrap(
    input logic [pts_pkg::COUNT_W-1:0] cur,
    input logic [pts_pkg::COUNT_W-1:0] prev,
    input logic                        inv
  );
    logic [pts_pkg::COUNT_W-1:0] diff;
    logic [pts_pkg::COUNT_W:0]   d;
    diff = cur - prev;
    d = {diff[pts_pkg::COUNT_W-1], diff};
    return inv ? (~d + 1'b1) : d;
  endfunction

  function automatic logic [pts_pkg::TRAVEL_W-1:0] sat_add(
    input logic [pts_pkg::TRAVEL_W-1:0] acc,
    input logic [pts_pkg::COUNT_W:0]    d
  );
    logic [pts_pkg::TRAVEL_W:0] s;
    s = {acc[pts_pkg::TRAVEL_W-1], acc}
      + {{(pts_pkg::TRAVEL_W - pts_pkg::COUNT_W){d[pts_pkg::COUNT_W]}}, d};
    if (s[pts_pkg::TRAVEL_W] != s[pts_pkg::TRAVEL_W-1]) begin
      return s[pts_pkg::TRAVEL_W] ? {1'b1, {(pts_pkg::TRAVEL_W-1){1'b0}}}
                                  : {1'b0, {(pts_pkg::TRAVEL_W-1){1'b1}}};
    end
    return s[pts_pkg::TRAVEL_W-1:0];
  endfunction

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_idx   = paddr[pts_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      approach_target   <= pts_pkg::RST_APPROACH_TARGET;
      confirm_count     <= pts_pkg::RST_CONFIRM_COUNT;
      timeout_limit     <= pts_pkg::RST_TIMEOUT_LIMIT;
      approach_duty     <= pts_pkg::RST_APPROACH_DUTY;
      rotate_duty       <= pts_pkg::RST_ROTATE_DUTY;
      left_sign_invert  <= 1'b0;
      right_sign_invert <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        pts_pkg::REG_APPROACH_TARGET: approach_target <= pwdata[pts_pkg::TARGET_W-1:0];
        pts_pkg::REG_CONFIRM_COUNT:   confirm_count   <= pwdata[pts_pkg::RUN_W-1:0];
        pts_pkg::REG_TIMEOUT_LIMIT:   timeout_limit   <= pwdata[pts_pkg::COUNT_W-1:0];
        pts_pkg::REG_APPROACH_DUTY:   approach_duty   <= pwdata[pts_pkg::DUTY_W-1:0];
        pts_pkg::REG_ROTATE_DUTY:     rotate_duty     <= pwdata[pts_pkg::DUTY_W-1:0];
        pts_pkg::REG_LEFT_INVERT:     left_sign_invert  <= pwdata[0];
        pts_pkg::REG_RIGHT_INVERT:    right_sign_invert <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      pts_pkg::REG_APPROACH_TARGET: prdata = {1'b0, approach_target};
      pts_pkg::REG_CONFIRM_COUNT:   prdata = {24'd0, confirm_count};
      pts_pkg::REG_TIMEOUT_LIMIT:   prdata = {16'd0, timeout_limit};
      pts_pkg::REG_APPROACH_DUTY:   prdata = {25'd0, approach_duty};
      pts_pkg::REG_ROTATE_DUTY:     prdata = {25'd0, rotate_duty};
      pts_pkg::REG_LEFT_INVERT:     prdata = {31'd0, left_sign_invert};
      pts_pkg::REG_RIGHT_INVERT:    prdata = {31'd0, right_sign_invert};
      default:                      prdata = '0;
    endcase
  end

  // datapath
  assign tick_inc  = (tick_count == '1) ? tick_count : tick_count + 1'b1;
  assign timed_out = (tick_inc >= timeout_limit);

  assign left_delta  = unwrap(left_count, last_left, left_sign_invert);
  assign right_delta = unwrap(right_count, last_right, right_sign_invert);
  assign left_sum    = sat_add(left_travel, left_delta);
  assign right_sum   = sat_add(right_travel, right_delta);
  assign travel_ok   = !left_sum[pts_pkg::TRAVEL_W-1]
                    && (left_sum[pts_pkg::TARGET_W-1:0] >= approach_target)
                    && !right_sum[pts_pkg::TRAVEL_W-1]
                    && (right_sum[pts_pkg::TARGET_W-1:0] >= approach_target);

  always_comb begin
    case (phase_reg)
      pts_pkg::PH_APPROACH: confirm_cond = travel_ok;
      pts_pkg::PH_LEAVE:    confirm_cond = !mid_left_black && !mid_right_black;
      pts_pkg::PH_FIND:     confirm_cond = mid_left_black && mid_right_black;
      default:              confirm_cond = 1'b0;
    endcase
  end

  assign run_inc = (confirm_run == '1) ? confirm_run : confirm_run + 1'b1;
  assign confirm_hit = confirm_cond && (run_inc >= confirm_count);
  assign confirm_run_new = (!confirm_cond || confirm_hit) ? '0 : run_inc;

  assign a_duty = pts_pkg::duty_sat(approach_duty);
  assign r_duty = pts_pkg::duty_sat(rotate_duty);
  assign a_mag  = {1'b0, a_duty};
  assign r_mag  = {1'b0, r_duty};

  always_comb begin
    phase_next        = phase_reg;
    turn_dir_next     = turn_dir;
    confirm_run_next  = confirm_run;
    tick_count_next   = tick_count;
    last_left_next    = last_left;
    last_right_next   = last_right;
    left_travel_next  = left_travel;
    right_travel_next = right_travel;
    res.start_accepted = 1'b0;
    res.drive_valid    = 1'b0;
    res.left_drive     = '0;
    res.right_drive    = '0;
    case (func)
      pts_pkg::FUNC_START: begin
        if (phase_reg == pts_pkg::PH_IDLE) begin
          turn_dir_next      = direction;
          confirm_run_next   = '0;
          tick_count_next    = '0;
          left_travel_next   = '0;
          right_travel_next  = '0;
          last_left_next     = left_count;
          last_right_next    = right_count;
          phase_next         = pts_pkg::PH_APPROACH;
          res.start_accepted = 1'b1;
          res.drive_valid    = 1'b1;
        end
      end
      pts_pkg::FUNC_ACK: begin
        if (phase_reg inside {pts_pkg::PH_DONE, pts_pkg::PH_FAULT}) begin
          confirm_run_next = '0;
          tick_count_next  = '0;
          phase_next       = pts_pkg::PH_IDLE;
          res.drive_valid  = 1'b1;
        end
      end
      pts_pkg::FUNC_TICK: begin
        if (phase_reg != pts_pkg::PH_IDLE) begin
          res.drive_valid = 1'b1;
          if (!(phase_reg inside {pts_pkg::PH_DONE, pts_pkg::PH_FAULT})) begin
            tick_count_next = tick_inc;
            if (timed_out) begin
              confirm_run_next = '0;
              phase_next       = pts_pkg::PH_FAULT;
            end else if (phase_reg == pts_pkg::PH_APPROACH) begin
              left_travel_next  = left_sum;
              right_travel_next = right_sum;
              last_left_next    = left_count;
              last_right_next   = right_count;
              confirm_run_next  = confirm_run_new;
              if (confirm_hit) phase_next = pts_pkg::PH_LEAVE;
            end else if (phase_reg == pts_pkg::PH_LEAVE) begin
              confirm_run_next = confirm_run_new;
              if (confirm_hit) phase_next = pts_pkg::PH_FIND;
            end else if (phase_reg == pts_pkg::PH_FIND) begin
              confirm_run_next = confirm_run_new;
              if (confirm_hit) phase_next = pts_pkg::PH_DONE;
            end else begin
              phase_next = pts_pkg::PH_FAULT;
            end
          end
        end
      end
      default: ;
    endcase
    res.phase = phase_next;
    if (res.drive_valid) begin
      if (phase_next == pts_pkg::PH_APPROACH) begin
        res.left_drive  = a_mag;
        res.right_drive = a_mag;
      end else if (phase_next inside {pts_pkg::PH_LEAVE, pts_pkg::PH_FIND}) begin
        res.left_drive  = turn_dir_next ? r_mag : -r_mag;
        res.right_drive = turn_dir_next ? -r_mag : r_mag;
      end
    end
  end

  // sequencer state
  assign in_ready = !skid_valid;
  assign in_xfer  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= pts_pkg::PH_IDLE;
      turn_dir     <= 1'b0;
      confirm_run  <= '0;
      tick_count   <= '0;
      last_left    <= '0;
      last_right   <= '0;
      left_travel  <= '0;
      right_travel <= '0;
    end else if (in_xfer) begin
      phase_reg    <= phase_next;
      turn_dir     <= turn_dir_next;
      confirm_run  <= confirm_run_next;
      tick_count   <= tick_count_next;
      last_left    <= last_left_next;
      last_right   <= last_right_next;
      left_travel  <= left_travel_next;
      right_travel <= right_travel_next;
    end
  end

  // result register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= in_xfer;
      end else begin
        out_valid  <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (in_xfer) skid_data <= res;
      end else if (in_xfer) begin
        out_data <= res;
      end
    end else if (in_xfer) begin
      skid_data <= res;
    end
  end

  assign phase          = out_data.phase;
  assign start_accepted = out_data.start_accepted;
  assign drive_valid    = out_data.drive_valid;
  assign left_drive     = out_data.left_drive;
  assign right_drive    = out_data.right_drive;

endmodule

>>> rtl/core/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks for the pivot turn sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [pts_pkg::PHASE_W-1:0]         phase,
  input logic                                start_accepted,
  input logic                                drive_valid,
  input logic signed [pts_pkg::DRIVE_W-1:0]  left_drive,
  input logic signed [pts_pkg::DRIVE_W-1:0]  right_drive
);

  a_start_drives: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_accepted |-> drive_valid && phase == pts_pkg::PH_APPROACH)
    else $error("accepted start without approach drive");

  a_no_drive_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_valid |-> left_drive == 0 && right_drive == 0)
    else $error("nonzero drive without command");

  a_rotate_opposed: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_valid && (phase == pts_pkg::PH_LEAVE || phase == pts_pkg::PH_FIND)
    |-> left_drive == -right_drive)
    else $error("rotation drive not opposed");

  a_ready_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && $past(out_valid && !out_ready))
    else $error("input closed without a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(left_drive))
    else $error("stalled result changed");

endmodule

bind pivot_turn_sequencer pts_checker u_pts_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .phase          (phase),
  .start_accepted (start_accepted),
  .drive_valid    (drive_valid),
  .left_drive     (left_drive),
  .right_drive    (right_drive)
);

>>> sim/pivot_turn_sequencer_tb.sv
// ----------------------------------------------------------------------------
// pivot_turn_sequencer_tb
// Self-checking bench for the junction turn sequencer. A queue of items feeds
// a valid/ready driver and a monitor checks every result, field by field,
// against an in-bench model of the turn phases, encoder travel, confirmation
// runs and timeout. Configuration changes go through the APB port between
// phases, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module pivot_turn_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pts_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam longint TRAVEL_MAX = 2147483647;
  localparam longint TRAVEL_MIN = -TRAVEL_MAX - 1;

  typedef struct {
    logic [pts_pkg::FUNC_W-1:0]  func;
    logic                        direction;
    logic [pts_pkg::COUNT_W-1:0] left_count;
    logic [pts_pkg::COUNT_W-1:0] right_count;
    logic                        mid_left_black;
    logic                        mid_right_black;
  } turn_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [pts_pkg::FUNC_W-1:0] func = pts_pkg::FUNC_TICK;
  logic direction = 1'b0;
  logic signed [pts_pkg::COUNT_W-1:0] left_count = '0;
  logic signed [pts_pkg::COUNT_W-1:0] right_count = '0;
  logic mid_left_black = 1'b0;
  logic mid_right_black = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [pts_pkg::PHASE_W-1:0] phase;
  logic start_accepted;
  logic drive_valid;
  logic signed [pts_pkg::DRIVE_W-1:0] left_drive;
  logic signed [pts_pkg::DRIVE_W-1:0] right_drive;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pts_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pivot_turn_sequencer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .direction(direction),
    .left_count(left_count), .right_count(right_count),
    .mid_left_black(mid_left_black), .mid_right_black(mid_right_black),
    .out_valid(out_valid), .out_ready(out_ready),
    .phase(phase), .start_accepted(start_accepted), .drive_valid(drive_valid),
    .left_drive(left_drive), .right_drive(right_drive),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model configuration and turn state
  logic [pts_pkg::TARGET_W-1:0] cfg_target = pts_pkg::RST_APPROACH_TARGET;
  logic [pts_pkg::RUN_W-1:0] cfg_confirm = pts_pkg::RST_CONFIRM_COUNT;
  logic [pts_pkg::COUNT_W-1:0] cfg_timeout = pts_pkg::RST_TIMEOUT_LIMIT;
  logic [pts_pkg::DUTY_W-1:0] cfg_app_duty = pts_pkg::RST_APPROACH_DUTY;
  logic [pts_pkg::DUTY_W-1:0] cfg_rot_duty = pts_pkg::RST_ROTATE_DUTY;
  logic cfg_inv_l = 1'b0;
  logic cfg_inv_r = 1'b0;

  logic [pts_pkg::PHASE_W-1:0] turn_phase = pts_pkg::PH_IDLE;
  logic rotate_cw = 1'b0;
  logic [pts_pkg::RUN_W-1:0] confirm_run = '0;
  logic [pts_pkg::COUNT_W-1:0] tick_count = '0;
  logic [pts_pkg::COUNT_W-1:0] last_left = '0;
  logic [pts_pkg::COUNT_W-1:0] last_right = '0;
  int left_travel = 0;
  int right_travel = 0;

  turn_item_t turn_items[$];
  pts_pkg::result_t turn_results_due[$];
  turn_item_t on_wire;
  int unsigned items_queued = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int mismatches = 0;
  bit idling_on = 1'b1;
  logic [pts_pkg::COUNT_W-1:0] gen_left = '0;
  logic [pts_pkg::COUNT_W-1:0] gen_right = '0;

  function automatic int wheel_delta(logic [pts_pkg::COUNT_W-1:0] cur,
                                     logic [pts_pkg::COUNT_W-1:0] prev, logic inv);
    logic [pts_pkg::COUNT_W-1:0] diff;
    int d;
    diff = cur - prev;
    d = int'($signed(diff));
    return inv ? -d : d;
  endfunction

  function automatic int travel_add(int acc, int d);
    longint s;
    s = longint'(acc) + longint'(d);
    if (s > TRAVEL_MAX) s = TRAVEL_MAX;
    if (s < TRAVEL_MIN) s = TRAVEL_MIN;
    return int'(s);
  endfunction

  function automatic logic confirm_step(logic cond);
    if (!cond) begin
      confirm_run = '0;
      return 1'b0;
    end
    if (confirm_run != 8'hFF) confirm_run++;
    if (confirm_run >= cfg_confirm) begin
      confirm_run = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic signed [pts_pkg::DRIVE_W-1:0] duty_limit(
    logic [pts_pkg::DUTY_W-1:0] d);
    return (d > pts_pkg::DUTY_MAX) ? pts_pkg::DRIVE_W'(pts_pkg::DUTY_MAX)
                                   : pts_pkg::DRIVE_W'(d);
  endfunction

  function automatic void phase_drive(output logic signed [pts_pkg::DRIVE_W-1:0] l,
                                      output logic signed [pts_pkg::DRIVE_W-1:0] r);
    logic signed [pts_pkg::DRIVE_W-1:0] m;
    l = '0;
    r = '0;
    if (turn_phase == pts_pkg::PH_APPROACH) begin
      l = duty_limit(cfg_app_duty);
      r = l;
    end else if (turn_phase == pts_pkg::PH_LEAVE || turn_phase == pts_pkg::PH_FIND) begin
      m = duty_limit(cfg_rot_duty);
      l = rotate_cw ? m : -m;
      r = rotate_cw ? -m : m;
    end
  endfunction

  function automatic pts_pkg::result_t sequence_turn(turn_item_t it);
    pts_pkg::result_t res;
    logic signed [pts_pkg::DRIVE_W-1:0] l;
    logic signed [pts_pkg::DRIVE_W-1:0] r;
    longint tgt;
    res = '0;
    l = '0;
    r = '0;
    tgt = cfg_target;
    case (it.func)
      pts_pkg::FUNC_START: begin
        if (turn_phase == pts_pkg::PH_IDLE) begin
          rotate_cw = it.direction;
          confirm_run = '0;
          tick_count = '0;
          left_travel = 0;
          right_travel = 0;
          last_left = it.left_count;
          last_right = it.right_count;
          turn_phase = pts_pkg::PH_APPROACH;
          res.start_accepted = 1'b1;
          res.drive_valid = 1'b1;
          phase_drive(l, r);
        end
      end
      pts_pkg::FUNC_ACK: begin
        if (turn_phase == pts_pkg::PH_DONE || turn_phase == pts_pkg::PH_FAULT) begin
          confirm_run = '0;
          tick_count = '0;
          turn_phase = pts_pkg::PH_IDLE;
          res.drive_valid = 1'b1;
        end
      end
      pts_pkg::FUNC_TICK: begin
        if (turn_phase != pts_pkg::PH_IDLE) begin
          res.drive_valid = 1'b1;
          if (turn_phase != pts_pkg::PH_DONE && turn_phase != pts_pkg::PH_FAULT) begin
            if (tick_count != 16'hFFFF) tick_count++;
            if (tick_count >= cfg_timeout) begin
              confirm_run = '0;
              turn_phase = pts_pkg::PH_FAULT;
            end else if (turn_phase == pts_pkg::PH_APPROACH) begin
              left_travel = travel_add(left_travel,
                                       wheel_delta(it.left_count, last_left, cfg_inv_l));
              right_travel = travel_add(right_travel,
                                        wheel_delta(it.right_count, last_right, cfg_inv_r));
              last_left = it.left_count;
              last_right = it.right_count;
              if (confirm_step(left_travel >= tgt && right_travel >= tgt))
                turn_phase = pts_pkg::PH_LEAVE;
            end else if (turn_phase == pts_pkg::PH_LEAVE) begin
              if (confirm_step(!it.mid_left_black && !it.mid_right_black))
                turn_phase = pts_pkg::PH_FIND;
            end else if (turn_phase == pts_pkg::PH_FIND) begin
              if (confirm_step(it.mid_left_black && it.mid_right_black))
                turn_phase = pts_pkg::PH_DONE;
            end else begin
              turn_phase = pts_pkg::PH_FAULT;
            end
          end
          phase_drive(l, r);
        end
      end
      default: ;
    endcase
    res.phase = turn_phase;
    res.left_drive = l;
    res.right_drive = r;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) turn_results_due.push_back(sequence_turn(on_wire));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (turn_items.size() > 0) begin
          on_wire = turn_items.pop_front();
          func <= on_wire.func;
          direction <= on_wire.direction;
          left_count <= on_wire.left_count;
          right_count <= on_wire.right_count;
          mid_left_black <= on_wire.mid_left_black;
          mid_right_black <= on_wire.mid_right_black;
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pts_pkg::result_t due;
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (turn_results_due.size() == 0) begin
          $error("unexpected result transfer, phase %0d", phase);
          mismatches++;
        end else begin
          due = turn_results_due.pop_front();
          check_field("phase", due.phase, phase);
          check_field("start_accepted", due.start_accepted, start_accepted);
          check_field("drive_valid", due.drive_valid, drive_valid);
          check_field("left_drive", due.left_drive, left_drive);
          check_field("right_drive", due.right_drive, right_drive);
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_stall <= pick_gap();
      end
    end
  end

  task automatic write_reg(logic [pts_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pts_pkg::REG_APPROACH_TARGET: cfg_target = val[pts_pkg::TARGET_W-1:0];
      pts_pkg::REG_CONFIRM_COUNT:   cfg_confirm = val[pts_pkg::RUN_W-1:0];
      pts_pkg::REG_TIMEOUT_LIMIT:   cfg_timeout = val[pts_pkg::COUNT_W-1:0];
      pts_pkg::REG_APPROACH_DUTY:   cfg_app_duty = val[pts_pkg::DUTY_W-1:0];
      pts_pkg::REG_ROTATE_DUTY:     cfg_rot_duty = val[pts_pkg::DUTY_W-1:0];
      pts_pkg::REG_LEFT_INVERT:     cfg_inv_l = val[0];
      pts_pkg::REG_RIGHT_INVERT:    cfg_inv_r = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] target, logic [31:0] confirm, logic [31:0] limit,
                            logic [31:0] app_duty, logic [31:0] rot_duty,
                            logic inv_l, logic inv_r);
    write_reg(pts_pkg::REG_APPROACH_TARGET, target);
    write_reg(pts_pkg::REG_CONFIRM_COUNT, confirm);
    write_reg(pts_pkg::REG_TIMEOUT_LIMIT, limit);
    write_reg(pts_pkg::REG_APPROACH_DUTY, app_duty);
    write_reg(pts_pkg::REG_ROTATE_DUTY, rot_duty);
    write_reg(pts_pkg::REG_LEFT_INVERT, 32'(inv_l));
    write_reg(pts_pkg::REG_RIGHT_INVERT, 32'(inv_r));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (turn_items.size() != 0 || in_valid || turn_results_due.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  function automatic turn_item_t noise_item();
    turn_item_t it;
    it.func = pts_pkg::FUNC_W'($urandom_range(0, 3));
    it.direction = 1'($urandom);
    it.left_count = pts_pkg::COUNT_W'($urandom);
    it.right_count = pts_pkg::COUNT_W'($urandom);
    it.mid_left_black = 1'($urandom);
    it.mid_right_black = 1'($urandom);
    return it;
  endfunction

  function automatic turn_item_t tick_item(logic ml, logic mr);
    turn_item_t it;
    it.func = pts_pkg::FUNC_TICK;
    it.direction = 1'($urandom);
    it.left_count = gen_left;
    it.right_count = gen_right;
    it.mid_left_black = ml;
    it.mid_right_black = mr;
    return it;
  endfunction

  task automatic push_item(turn_item_t it);
    turn_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_tick(logic ml, logic mr);
    push_item(($urandom_range(0, 99) < 8) ? noise_item() : tick_item(ml, mr));
  endtask

  task automatic queue_turn(bit probes);
    turn_item_t it;
    longint tgt;
    longint span;
    longint fwd_l;
    longint fwd_r;
    int step_l;
    int step_r;
    int unsigned extra;
    int unsigned steps;
    int unsigned n;
    if ($urandom_range(0, 3) == 0) begin
      gen_left = pts_pkg::COUNT_W'($urandom);
      gen_right = pts_pkg::COUNT_W'($urandom);
    end
    it = tick_item(1'($urandom), 1'($urandom));
    it.func = pts_pkg::FUNC_START;
    push_item(it);
    if (probes) begin
      it.direction = ~it.direction;
      push_item(it);
      it.func = pts_pkg::FUNC_ACK;
      push_item(it);
      it.func = FUNC_UNUSED;
      push_item(it);
    end
    tgt = cfg_target;
    span = tgt / 3 + 8;
    if (span > 32767 || $urandom_range(0, 7) == 0) span = 32767;
    fwd_l = 0;
    fwd_r = 0;
    steps = 0;
    extra = ((cfg_confirm > 6) ? 6 : cfg_confirm) + $urandom_range(0, 1);
    while (steps < 40 && extra > 0) begin
      step_l = $urandom_range(0, span);
      step_r = $urandom_range(0, span);
      if ($urandom_range(0, 9) == 0) step_l = -step_l;
      if ($urandom_range(0, 9) == 0) step_r = -step_r;
      fwd_l += step_l;
      fwd_r += step_r;
      gen_left += pts_pkg::COUNT_W'(cfg_inv_l ? -step_l : step_l);
      gen_right += pts_pkg::COUNT_W'(cfg_inv_r ? -step_r : step_r);
      push_tick(1'($urandom), 1'($urandom));
      if (fwd_l >= tgt && fwd_r >= tgt) extra--;
      steps++;
    end
    n = ((cfg_confirm > 6) ? 6 : cfg_confirm) + $urandom_range(0, 2);
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) push_tick(1'b0, 1'b0);
      else push_tick(1'($urandom), 1'($urandom));
    end
    n = ((cfg_confirm > 6) ? 6 : cfg_confirm) + $urandom_range(0, 2);
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) push_tick(1'b1, 1'b1);
      else push_tick(1'($urandom), 1'($urandom));
    end
    repeat ($urandom_range(0, 2)) push_tick(1'($urandom), 1'($urandom));
    if ($urandom_range(0, 99) < 85) begin
      it = tick_item(1'($urandom), 1'($urandom));
      it.func = pts_pkg::FUNC_ACK;
      push_item(it);
    end
    repeat ($urandom_range(0, 2)) push_item(noise_item());
  endtask

  initial begin
    turn_item_t it;
    int unsigned goal;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // idle probes, then a turn usually starting from the counter extremes
    it = tick_item(1'b1, 1'b0);
    push_item(it);
    it.func = pts_pkg::FUNC_ACK;
    push_item(it);
    it.func = FUNC_UNUSED;
    push_item(it);
    gen_left = 16'h7FFF;
    gen_right = 16'h8000;
    queue_turn(1'b1);
    queue_turn(1'b0);
    wait_drained();

    set_config(32'd0, 32'd0, 32'd0, 32'd127, 32'd0, 1'b1, 1'b0);
    queue_turn(1'b1);
    queue_turn(1'b0);
    wait_drained();

    set_config(32'h7FFF_FFFF, 32'd255, 32'd1, 32'd0, 32'd100, 1'b0, 1'b1);
    queue_turn(1'b0);
    queue_turn(1'b0);
    wait_drained();

    idling_on = 1'b0;
    set_config(32'd50, 32'd1, 32'd65535, 32'd100, 32'd127, 1'b1, 1'b1);
    repeat (3) queue_turn(1'b0);
    wait_drained();

    while (items_queued < 370) begin
      set_config(($urandom_range(0, 4) == 0) ? 32'd0 :
                 ($urandom_range(0, 7) == 0) ? 32'($urandom_range(30000, 300000)) :
                 32'($urandom_range(1, 3000)),
                 32'($urandom_range(0, 5)),
                 ($urandom_range(0, 9) == 0) ? 32'($urandom_range(1, 10)) :
                 32'($urandom_range(25, 200)),
                 32'($urandom_range(0, 127)), 32'($urandom_range(0, 127)),
                 1'($urandom), 1'($urandom));
      idling_on = ($urandom_range(0, 3) != 0);
      goal = items_queued + 50;
      while (items_queued < goal) queue_turn(1'b0);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
